// ----- hdl/pdt_pkg.sv -----
package pdt_pkg;

    localparam int COORD_W    = 24;
    localparam int SIZE_W     = 23;
    localparam int AREA_W     = 48;
    localparam int DENS_W     = 32;
    localparam int FRAC_W     = 16;
    localparam int CLIP_W     = COORD_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int DIV_CNT_W  = $clog2(DENS_W);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BIN_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_TOP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_AREA = 3'd4;

    // command codes
    localparam logic CMD_MOVE_IN  = 1'b0;
    localparam logic CMD_MOVE_OUT = 1'b1;

    typedef struct packed {
        logic                      command;
        logic signed [COORD_W-1:0] cell_center_x;
        logic signed [COORD_W-1:0] cell_center_y;
        logic [SIZE_W-1:0]         cell_width;
        logic [SIZE_W-1:0]         cell_height;
        logic                      is_terminal;
        logic                      is_non_image;
    } pdt_in_t;

    typedef struct packed {
        logic [AREA_W-1:0] overlap_area;
        logic [DENS_W-1:0] density;
        logic              low_free_space;
        logic              no_overlap;
    } pdt_out_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pdt_div_stat_t;

endpackage

// ----- hdl/pdt_div.sv -----
// Radix-2 restoring divider: {occupied, 16'b0} / free_left, 32-bit quotient.
// Caller guarantees the quotient fits (occupied < free_left << 16).
module pdt_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [pdt_pkg::AREA_W-1:0] occupied,
    input  logic [pdt_pkg::AREA_W-1:0] free_left,
    output pdt_pkg::pdt_div_stat_t    stat,
    output logic [pdt_pkg::DENS_W-1:0] quotient
);

    logic                           busy_reg;
    logic                           done_reg;
    logic [pdt_pkg::DIV_CNT_W-1:0]  cnt_reg;
    logic [pdt_pkg::AREA_W-1:0]     rem_reg;
    logic [pdt_pkg::AREA_W-1:0]     div_reg;
    logic [pdt_pkg::DENS_W-1:0]     dvd_reg;
    logic [pdt_pkg::DENS_W-1:0]     quo_reg;

    logic [pdt_pkg::AREA_W:0]       shifted;
    logic [pdt_pkg::AREA_W:0]       diff;
    logic                           ge;
    logic [pdt_pkg::AREA_W-1:0]     rem_next;

    // one shift-compare-subtract per cycle
    assign shifted  = {rem_reg, dvd_reg[pdt_pkg::DENS_W-1]};
    assign ge       = shifted >= {1'b0, div_reg};
    assign diff     = shifted - {1'b0, div_reg};
    assign rem_next = ge ? diff[pdt_pkg::AREA_W-1:0] : shifted[pdt_pkg::AREA_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + pdt_pkg::DIV_CNT_W'(1);
                if (cnt_reg == pdt_pkg::DIV_CNT_W'(pdt_pkg::DENS_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= pdt_pkg::AREA_W'(occupied[pdt_pkg::AREA_W-1:pdt_pkg::FRAC_W]);
            dvd_reg <= {occupied[pdt_pkg::FRAC_W-1:0], {(pdt_pkg::DENS_W-pdt_pkg::FRAC_W){1'b0}}};
            div_reg <= free_left;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[pdt_pkg::DENS_W-2:0], 1'b0};
            quo_reg <= {quo_reg[pdt_pkg::DENS_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

// ----- hdl/placement_bin_density_tracker.sv -----
// Result path: a cell that misses the bin goes from S_SIDE straight to S_FINISH;
// low free space or a saturated density ends at S_CHECK; else the divider runs.
// Throughput: one item at a time; the 32-step divider sets the longest item time.
// Input is taken again once the result is in the output register.
// Reset (rst_n, async, active low): bin limits, total area, free area, occupied
// area and density all clear to zero; the sequencer returns to idle.
module placement_bin_density_tracker (
    input  logic                          clk,
    input  logic                          rst_n,
    // input items
    input  logic                          in_valid,
    output logic                          in_stall,
    input  pdt_pkg::pdt_in_t              in_data,
    // result items
    output logic                          out_valid,
    input  logic                          out_stall,
    output pdt_pkg::pdt_out_t             out_data,
    // configuration writes
    input  logic                          cfg_en,
    input  logic [pdt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pdt_pkg::CFG_DATA_W-1:0] cfg_data
);

    // Sequencer: clip the cell, form the side lengths, multiply, update the
    // area bookkeeping, check free space and saturation, then run the divider.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLIP,
        S_SIDE,
        S_MUL,
        S_UPDATE,
        S_CHECK,
        S_DIV,
        S_FINISH
    } state_t;

    state_t state_reg;

    // configuration
    logic signed [pdt_pkg::COORD_W-1:0] bin_left_reg;
    logic signed [pdt_pkg::COORD_W-1:0] bin_right_reg;
    logic signed [pdt_pkg::COORD_W-1:0] bin_bottom_reg;
    logic signed [pdt_pkg::COORD_W-1:0] bin_top_reg;
    logic [pdt_pkg::AREA_W-1:0]         total_area_reg;

    // bin state
    logic [pdt_pkg::AREA_W-1:0]         occ_reg;
    logic [pdt_pkg::AREA_W-1:0]         free_reg;
    logic [pdt_pkg::DENS_W-1:0]         cur_density_reg;

    // per-item working registers
    pdt_pkg::pdt_in_t                   item_reg;
    logic signed [pdt_pkg::CLIP_W-1:0]  clip_l_reg;
    logic signed [pdt_pkg::CLIP_W-1:0]  clip_r_reg;
    logic signed [pdt_pkg::CLIP_W-1:0]  clip_b_reg;
    logic signed [pdt_pkg::CLIP_W-1:0]  clip_t_reg;
    logic [pdt_pkg::SIZE_W-1:0]         w_reg;
    logic [pdt_pkg::SIZE_W-1:0]         h_reg;
    logic [pdt_pkg::AREA_W-1:0]         area_reg;
    logic                               empty_reg;
    logic                               low_reg;
    logic                               div_start_reg;

    // output register
    logic                               out_valid_reg;
    pdt_pkg::pdt_out_t                  out_data_reg;

    // divider
    pdt_pkg::pdt_div_stat_t             div_stat;
    logic [pdt_pkg::DENS_W-1:0]         div_quo;

    // clip arithmetic, 25-bit signed so cx +/- w/2 never wraps
    logic signed [pdt_pkg::CLIP_W-1:0]  half_w;
    logic signed [pdt_pkg::CLIP_W-1:0]  half_h;
    logic signed [pdt_pkg::CLIP_W-1:0]  cx;
    logic signed [pdt_pkg::CLIP_W-1:0]  cy;
    logic signed [pdt_pkg::CLIP_W-1:0]  x_lo;
    logic signed [pdt_pkg::CLIP_W-1:0]  x_hi;
    logic signed [pdt_pkg::CLIP_W-1:0]  y_lo;
    logic signed [pdt_pkg::CLIP_W-1:0]  y_hi;
    logic signed [pdt_pkg::CLIP_W-1:0]  lim_l;
    logic signed [pdt_pkg::CLIP_W-1:0]  lim_r;
    logic signed [pdt_pkg::CLIP_W-1:0]  lim_b;
    logic signed [pdt_pkg::CLIP_W-1:0]  lim_t;
    logic signed [pdt_pkg::CLIP_W-1:0]  side_x;
    logic signed [pdt_pkg::CLIP_W-1:0]  side_y;

    logic [2*pdt_pkg::SIZE_W-1:0]       prod;
    logic [pdt_pkg::AREA_W:0]           occ_sum;
    logic [pdt_pkg::AREA_W-1:0]         occ_next;
    logic [pdt_pkg::AREA_W-1:0]         free_next;
    logic [pdt_pkg::AREA_W+2:0]         free_x5;
    logic                               low_now;
    logic                               sat_now;
    logic                               out_load;

    assign half_w = $signed(pdt_pkg::CLIP_W'(item_reg.cell_width >> 1));
    assign half_h = $signed(pdt_pkg::CLIP_W'(item_reg.cell_height >> 1));
    assign cx     = pdt_pkg::CLIP_W'(item_reg.cell_center_x);
    assign cy     = pdt_pkg::CLIP_W'(item_reg.cell_center_y);
    assign x_lo   = cx - half_w;
    assign x_hi   = cx + half_w;
    assign y_lo   = cy - half_h;
    assign y_hi   = cy + half_h;
    assign lim_l  = pdt_pkg::CLIP_W'(bin_left_reg);
    assign lim_r  = pdt_pkg::CLIP_W'(bin_right_reg);
    assign lim_b  = pdt_pkg::CLIP_W'(bin_bottom_reg);
    assign lim_t  = pdt_pkg::CLIP_W'(bin_top_reg);

    // A non-empty clip is never wider than the cell itself, so 23 bits hold it.
    assign side_x = clip_r_reg - clip_l_reg;
    assign side_y = clip_t_reg - clip_b_reg;

    assign prod = (2*pdt_pkg::SIZE_W)'(w_reg) * (2*pdt_pkg::SIZE_W)'(h_reg);

    // Area bookkeeping for one item
    assign occ_sum = {1'b0, occ_reg} + (pdt_pkg::AREA_W+1)'(area_reg);

    always_comb
    begin
        occ_next  = occ_reg;
        free_next = free_reg;
        priority if (item_reg.command == pdt_pkg::CMD_MOVE_OUT)
        begin
            occ_next = (occ_reg > area_reg) ? occ_reg - area_reg : '0;
        end
        else if (item_reg.is_terminal)
        begin
            if (!item_reg.is_non_image)
            begin
                free_next = (free_reg > area_reg) ? free_reg - area_reg : '0;
            end
        end
        else
        begin
            occ_next = occ_sum[pdt_pkg::AREA_W] ? '1 : occ_sum[pdt_pkg::AREA_W-1:0];
        end
    end

    // Low free space: 5 * free <= total. Zero free area always lands here.
    assign free_x5 = {1'b0, free_reg, 2'b00} + (pdt_pkg::AREA_W+3)'(free_reg);
    assign low_now = free_x5 <= (pdt_pkg::AREA_W+3)'(total_area_reg);
    // Quotient reaches 2^32 exactly when occupied >= free << 16.
    assign sat_now = (pdt_pkg::AREA_W+pdt_pkg::FRAC_W)'(occ_reg)
                     >= {free_reg, {pdt_pkg::FRAC_W{1'b0}}};

    // Output slot is free when empty or being drained this cycle
    assign out_load = (state_reg == S_FINISH) && (!out_valid_reg || !out_stall);

    // Control, configuration and bin state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            bin_left_reg    <= '0;
            bin_right_reg   <= '0;
            bin_bottom_reg  <= '0;
            bin_top_reg     <= '0;
            total_area_reg  <= '0;
            occ_reg         <= '0;
            free_reg        <= '0;
            cur_density_reg <= '0;
            div_start_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            div_start_reg <= 1'b0;

            if (cfg_en)
            begin
                unique case (cfg_index)
                    pdt_pkg::REG_BIN_LEFT:
                        bin_left_reg <= cfg_data[pdt_pkg::COORD_W-1:0];
                    pdt_pkg::REG_BIN_RIGHT:
                        bin_right_reg <= cfg_data[pdt_pkg::COORD_W-1:0];
                    pdt_pkg::REG_BIN_BOTTOM:
                        bin_bottom_reg <= cfg_data[pdt_pkg::COORD_W-1:0];
                    pdt_pkg::REG_BIN_TOP:
                        bin_top_reg <= cfg_data[pdt_pkg::COORD_W-1:0];
                    pdt_pkg::REG_TOTAL_AREA:
                    begin
                        // writing the total also restarts the free area
                        total_area_reg <= cfg_data[pdt_pkg::AREA_W-1:0];
                        free_reg       <= cfg_data[pdt_pkg::AREA_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_CLIP;
                    end
                end
                S_CLIP:
                begin
                    state_reg <= S_SIDE;
                end
                S_SIDE:
                begin
                    // missing the bin leaves all state alone
                    if (clip_l_reg > clip_r_reg || clip_b_reg > clip_t_reg)
                    begin
                        state_reg <= S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    occ_reg   <= occ_next;
                    free_reg  <= free_next;
                    state_reg <= S_CHECK;
                end
                S_CHECK:
                begin
                    priority if (low_now)
                    begin
                        cur_density_reg <= '0;
                        state_reg       <= S_FINISH;
                    end
                    else if (sat_now)
                    begin
                        cur_density_reg <= '1;
                        state_reg       <= S_FINISH;
                    end
                    else
                    begin
                        div_start_reg <= 1'b1;
                        state_reg     <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (div_stat.done)
                    begin
                        cur_density_reg <= div_quo;
                        state_reg       <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Per-item payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            item_reg <= in_data;
        end
        if (state_reg == S_CLIP)
        begin
            clip_l_reg <= (x_lo > lim_l) ? x_lo : lim_l;
            clip_r_reg <= (x_hi < lim_r) ? x_hi : lim_r;
            clip_b_reg <= (y_lo > lim_b) ? y_lo : lim_b;
            clip_t_reg <= (y_hi < lim_t) ? y_hi : lim_t;
        end
        if (state_reg == S_SIDE)
        begin
            empty_reg <= (clip_l_reg > clip_r_reg) || (clip_b_reg > clip_t_reg);
            w_reg     <= side_x[pdt_pkg::SIZE_W-1:0];
            h_reg     <= side_y[pdt_pkg::SIZE_W-1:0];
        end
        if (state_reg == S_MUL)
        begin
            area_reg <= pdt_pkg::AREA_W'(prod);
        end
        if (state_reg == S_CHECK)
        begin
            low_reg <= low_now;
        end
        if (out_load)
        begin
            out_data_reg.overlap_area   <= empty_reg ? '0 : area_reg;
            out_data_reg.density        <= cur_density_reg;
            out_data_reg.low_free_space <= !empty_reg && low_reg;
            out_data_reg.no_overlap     <= empty_reg;
        end
    end

    pdt_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start_reg),
        .occupied  (occ_reg),
        .free_left (free_reg),
        .stat      (div_stat),
        .quotient  (div_quo)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- hdl/pdt_checker.sv -----
module pdt_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              out_valid,
    input logic              out_stall,
    input pdt_pkg::pdt_out_t out_data
);

    // one item in flight: after taking an item the block is busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken again right after an accept");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.no_overlap |->
            out_data.overlap_area == '0 && !out_data.low_free_space)
        else $error("missed cell reports area or low free space");

    a_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.low_free_space |-> out_data.density == '0)
        else $error("low free space with nonzero density");

endmodule

bind placement_bin_density_tracker pdt_checker u_pdt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

// ----- test/testbench.sv -----
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned u64_t;

    localparam longint COORD_MAX   = 64'sd8388607;
    localparam longint COORD_MIN   = -64'sd8388608;
    localparam longint SIZE_MAX    = 64'sd8388607;
    localparam u64_t   AREA_MAX    = 64'hFFFF_FFFF_FFFF;
    localparam int     CYCLE_LIMIT = 600000;
    // wait well past the worst-case item time at the end
    localparam int     DRAIN_CYCLES = 100;
    localparam int     RAND_PHASES  = 12;
    localparam int     MOVES_PER_PHASE = 155;
    localparam int     MAX_REPORTS  = 200;

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    pdt_pkg::pdt_in_t               in_data   = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    pdt_pkg::pdt_out_t              out_data;
    logic                           cfg_en    = 1'b0;
    logic [pdt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [pdt_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    placement_bin_density_tracker i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_en    (cfg_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Local copy of the bin: limits, total area and the running areas.
    // Values match the block's reset state.
    // ------------------------------------------------------------------
    longint                     bin_lo_x  = 0;
    longint                     bin_hi_x  = 0;
    longint                     bin_lo_y  = 0;
    longint                     bin_hi_y  = 0;
    u64_t                       bin_area  = 0;
    u64_t                       occ_area  = 0;
    u64_t                       free_left = 0;
    logic [pdt_pkg::DENS_W-1:0] dens_now  = '0;

    pdt_pkg::pdt_in_t  pending_moves[$];   // items not yet taken by the block
    pdt_pkg::pdt_out_t density_due[$];     // predicted results, oldest first

    int  cycle_count = 0;
    int  errors      = 0;
    int  send_gap    = 0;
    int  hold_left   = 0;
    bit  quiet_in    = 1'b0;      // no sender gaps in this phase
    bit  quiet_out   = 1'b0;      // no receiver stalls in this phase

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor: one move into or out of the bin, updates the local areas
    // and returns the result the block must produce.
    // ------------------------------------------------------------------
    function automatic pdt_pkg::pdt_out_t apply_move(pdt_pkg::pdt_in_t mv);
        pdt_pkg::pdt_out_t res;
        longint   cx, cy, hw, hh, l, r, b, t;
        u64_t     area, quot;
        logic     low;
        cx = longint'($signed(mv.cell_center_x));
        cy = longint'($signed(mv.cell_center_y));
        hw = longint'(mv.cell_width >> 1);
        hh = longint'(mv.cell_height >> 1);
        // clip the rectangle to the bin
        l = (cx - hw > bin_lo_x) ? cx - hw : bin_lo_x;
        r = (cx + hw < bin_hi_x) ? cx + hw : bin_hi_x;
        b = (cy - hh > bin_lo_y) ? cy - hh : bin_lo_y;
        t = (cy + hh < bin_hi_y) ? cy + hh : bin_hi_y;
        res = '0;
        if (l > r || b > t)
        begin
            // misses the bin: state untouched, old density reported
            res.density    = dens_now;
            res.no_overlap = 1'b1;
            return res;
        end
        area = u64_t'((r - l) * (t - b));
        if (mv.command == pdt_pkg::CMD_MOVE_OUT)
        begin
            occ_area = (occ_area > area) ? occ_area - area : 0;
        end
        else if (mv.is_terminal)
        begin
            // non-image terminals block nothing
            if (!mv.is_non_image)
                free_left = (free_left > area) ? free_left - area : 0;
        end
        else
        begin
            occ_area = occ_area + area;
            if (occ_area > AREA_MAX)
                occ_area = AREA_MAX;
        end
        // zero free area always lands here, so no divide by zero below
        low = ((free_left * 5) <= bin_area);
        if (low)
        begin
            dens_now = '0;
        end
        else
        begin
            quot     = (occ_area << pdt_pkg::FRAC_W) / free_left;
            dens_now = (quot > 64'hFFFF_FFFF) ? '1 : quot[pdt_pkg::DENS_W-1:0];
        end
        res.overlap_area   = area[pdt_pkg::AREA_W-1:0];
        res.density        = dens_now;
        res.low_free_space = low;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: feeds pending_moves, holds the item while stalled, draws a
    // random gap after each accepted item.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                density_due.insert(density_due.size(), apply_move(in_data));
                void'(pending_moves.pop_front());
                send_gap = quiet_in ? 0 : $urandom_range(0, 10);
            end
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0 || pending_moves.size() == 0)
                begin
                    in_valid <= 1'b0;
                    if (send_gap > 0)
                        send_gap--;
                end
                else
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_moves[0];
                end
            end
        end
    end

    task automatic check_field(input string name, input u64_t want, input u64_t got);
        if (want != got)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: compares each accepted result with the oldest prediction.
    // After each result it draws a random stall count; the count mostly runs
    // down while a result is waiting, so stalls hit both the wait for the
    // divider and results already on the port.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        pdt_pkg::pdt_out_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (density_due.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t: unexpected result, expected none, actual %h",
                                 $time, out_data);
                end
                else
                begin
                    want = density_due.pop_front();
                    check_field("overlap_area", u64_t'(want.overlap_area),
                                u64_t'(out_data.overlap_area));
                    check_field("density", u64_t'(want.density), u64_t'(out_data.density));
                    check_field("low_free_space", u64_t'(want.low_free_space),
                                u64_t'(out_data.low_free_space));
                    check_field("no_overlap", u64_t'(want.no_overlap),
                                u64_t'(out_data.no_overlap));
                end
                hold_left = quiet_out ? 0 : $urandom_range(0, 10);
            end
            if (hold_left > 0 && (out_valid || $urandom_range(0, 7) == 0))
                hold_left--;
            out_stall <= (hold_left > 0);
        end
    end

    // ------------------------------------------------------------------
    // Configuration writes; only called while the block is idle, so the
    // local copy is updated right away.
    // ------------------------------------------------------------------
    task automatic write_reg(input logic [pdt_pkg::CFG_IDX_W-1:0] idx, input u64_t value);
        @(posedge clk);
        cfg_en    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[pdt_pkg::CFG_DATA_W-1:0];
        case (idx)
            pdt_pkg::REG_BIN_LEFT:
                bin_lo_x = longint'($signed(value[pdt_pkg::COORD_W-1:0]));
            pdt_pkg::REG_BIN_RIGHT:
                bin_hi_x = longint'($signed(value[pdt_pkg::COORD_W-1:0]));
            pdt_pkg::REG_BIN_BOTTOM:
                bin_lo_y = longint'($signed(value[pdt_pkg::COORD_W-1:0]));
            pdt_pkg::REG_BIN_TOP:
                bin_hi_y = longint'($signed(value[pdt_pkg::COORD_W-1:0]));
            pdt_pkg::REG_TOTAL_AREA:
            begin
                bin_area  = u64_t'(value[pdt_pkg::AREA_W-1:0]);
                free_left = bin_area;   // total area write refills free area
            end
            default: ;
        endcase
        @(posedge clk);
        cfg_en <= 1'b0;
    endtask

    // coordinates carry junk above bit 23, which must be ignored
    function automatic u64_t coord_word(longint c);
        return (u64_t'($urandom) << pdt_pkg::COORD_W) | (u64_t'(c) & 64'hFF_FFFF);
    endfunction

    task automatic write_bin(input longint l, input longint r, input longint b,
                             input longint t, input u64_t total);
        write_reg(pdt_pkg::REG_BIN_LEFT, coord_word(l));
        write_reg(pdt_pkg::REG_BIN_RIGHT, coord_word(r));
        write_reg(pdt_pkg::REG_BIN_BOTTOM, coord_word(b));
        write_reg(pdt_pkg::REG_BIN_TOP, coord_word(t));
        write_reg(pdt_pkg::REG_TOTAL_AREA, total);
    endtask

    // block idle: nothing queued, nothing on the port, nothing outstanding
    task automatic wait_drained();
        while (!(pending_moves.size() == 0 && !in_valid && density_due.size() == 0))
            @(posedge clk);
    endtask

    function automatic void add_move(pdt_pkg::pdt_in_t mv);
        pending_moves.insert(pending_moves.size(), mv);
    endfunction

    function automatic pdt_pkg::pdt_in_t mk_move(logic cmd, longint cx, longint cy,
                                                 longint w, longint h, logic term,
                                                 logic nonimg);
        pdt_pkg::pdt_in_t mv;
        mv.command       = cmd;
        mv.cell_center_x = cx[pdt_pkg::COORD_W-1:0];
        mv.cell_center_y = cy[pdt_pkg::COORD_W-1:0];
        mv.cell_width    = w[pdt_pkg::SIZE_W-1:0];
        mv.cell_height   = h[pdt_pkg::SIZE_W-1:0];
        mv.is_terminal   = term;
        mv.is_non_image  = nonimg;
        return mv;
    endfunction

    // mostly near the bin, sometimes anywhere in the coordinate range
    function automatic longint rand_coord(longint lo, longint hi);
        logic [pdt_pkg::COORD_W-1:0] raw;
        longint span, c;
        raw = pdt_pkg::COORD_W'($urandom);
        if ($urandom_range(0, 4) == 0 || hi < lo)
            return longint'($signed(raw));
        span = hi - lo;
        c = lo - span / 4 + longint'($urandom_range(0, 32'(span + span / 2)));
        if (c > COORD_MAX) c = COORD_MAX;
        if (c < COORD_MIN) c = COORD_MIN;
        return c;
    endfunction

    function automatic longint rand_size(longint span);
        logic [pdt_pkg::SIZE_W-1:0] raw;
        longint s;
        raw = pdt_pkg::SIZE_W'($urandom);
        if (span < 0) span = 100;
        case ($urandom_range(0, 9))
            0:       s = longint'(raw);
            1:       s = longint'($urandom_range(0, 3));
            default: s = longint'($urandom_range(0, 32'(span / 2 + 4)));
        endcase
        if (s > SIZE_MAX) s = SIZE_MAX;
        return s;
    endfunction

    function automatic pdt_pkg::pdt_in_t rand_move();
        pdt_pkg::pdt_in_t mv;
        longint  cx, cy, w, h;
        cx = rand_coord(bin_lo_x, bin_hi_x);
        cy = rand_coord(bin_lo_y, bin_hi_y);
        w  = rand_size(bin_hi_x - bin_lo_x);
        h  = rand_size(bin_hi_y - bin_lo_y);
        // move-ins dominate so occupied area builds up between move-outs
        mv = mk_move(($urandom_range(0, 99) < 30) ? pdt_pkg::CMD_MOVE_OUT
                                                  : pdt_pkg::CMD_MOVE_IN,
                     cx, cy, w, h, ($urandom_range(0, 7) == 0),
                     1'($urandom_range(0, 1)));
        return mv;
    endfunction

    task automatic random_bin();
        logic [pdt_pkg::COORD_W-1:0] raw;
        longint l, r, b, t;
        u64_t   total;
        raw = pdt_pkg::COORD_W'($urandom);
        l   = longint'($signed(raw));
        raw = pdt_pkg::COORD_W'($urandom);
        b   = longint'($signed(raw));
        case ($urandom_range(0, 9))
            0:
            begin            // whole coordinate range
                l = COORD_MIN; r = COORD_MAX; b = COORD_MIN; t = COORD_MAX;
            end
            1:
            begin            // inverted x limits, everything misses
                r = l - longint'($urandom_range(1, 1000));
                t = b + longint'($urandom_range(0, 1000));
            end
            2:
            begin            // zero-width bin
                r = l;
                t = b + longint'($urandom_range(0, 5000));
            end
            default:
            begin
                r = l + longint'($urandom_range(1, 20000));
                t = b + longint'($urandom_range(1, 20000));
            end
        endcase
        if (r > COORD_MAX) r = COORD_MAX;
        if (r < COORD_MIN) r = COORD_MIN;
        if (t > COORD_MAX) t = COORD_MAX;
        case ($urandom_range(0, 7))
            0:       total = {$urandom, $urandom} & AREA_MAX;
            1:       total = 0;
            2:       total = u64_t'($urandom_range(1, 1000));
            default: total = (r >= l && t >= b) ? u64_t'((r - l) * (t - b))
                                                : u64_t'($urandom);
        endcase
        write_bin(l, r, b, t, total);
    endtask

    // ------------------------------------------------------------------
    // Stimulus: directed moves over a few fixed bins, then random phases,
    // each with a fresh bin.  Every phase boundary waits for all results,
    // so the sender is held off until the block has drained.
    // ------------------------------------------------------------------
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset bin is the single point at the origin with no free area
        add_move(mk_move(pdt_pkg::CMD_MOVE_IN, 0, 0, 4, 4, 1'b0, 1'b0));
        add_move(mk_move(pdt_pkg::CMD_MOVE_IN, 100, 0, 4, 4, 1'b0, 1'b0));
        wait_drained();

        // ordinary bin, 2000 x 1000
        write_bin(-1000, 1000, -500, 500, 2000000);
        add_move(mk_move(pdt_pkg::CMD_MOVE_IN, 0, 0, 100, 50, 1'b0, 1'b0));
        // odd sizes round down; non-image flag on a movable cell is ignored
        add_move(mk_move(pdt_pkg::CMD_MOVE_IN, 0, 0, 101, 51, 1'b0, 1'b1));
        add_move(mk_move(pdt_pkg::CMD_MOVE_IN, 0, 0, 0, 0, 1'b0, 1'b0));
        add_move(mk_move(pdt_pkg::CMD_MOVE_IN, -1000, 0, 200, 100, 1'b0, 1'b0));
        // touches the left limit: zero area but not a miss
        add_move(mk_move(pdt_pkg::CMD_MOVE_IN, -1100, 0, 200, 2, 1'b0, 1'b0));
        // one unit short of the left limit: a miss
        add_move(mk_move(pdt_pkg::CMD_MOVE_IN, -1101, 0, 200, 2, 1'b0, 1'b0));
        add_move(mk_move(pdt_pkg::CMD_MOVE_IN, 5000, 5000, 10, 10, 1'b0, 1'b0));
        add_move(mk_move(pdt_pkg::CMD_MOVE_IN, 0, 0, 400, 400, 1'b1, 1'b1));
        add_move(mk_move(pdt_pkg::CMD_MOVE_IN, 0, 0, 400, 400, 1'b1, 1'b0));
        add_move(mk_move(pdt_pkg::CMD_MOVE_OUT, 0, 0, 20, 20, 1'b1, 1'b1));
        // move-out larger than the occupied area clamps at zero
        add_move(mk_move(pdt_pkg::CMD_MOVE_OUT, 0, 0, SIZE_MAX, SIZE_MAX, 1'b0, 1'b0));
        add_move(mk_move(pdt_pkg::CMD_MOVE_IN, 0, 0, SIZE_MAX, SIZE_MAX, 1'b0, 1'b0));
        // terminal over the whole bin: free area clamps at zero
        add_move(mk_move(pdt_pkg::CMD_MOVE_IN, 0, 0, SIZE_MAX, SIZE_MAX, 1'b1, 1'b0));
        add_move(mk_move(pdt_pkg::CMD_MOVE_IN, COORD_MAX, COORD_MIN, SIZE_MAX,
                         SIZE_MAX, 1'b0, 1'b0));
        wait_drained();

        // full coordinate range, tiny total area: occupied and density saturate
        write_bin(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX, 100);
        for (int i = pdt_pkg::REG_TOTAL_AREA + 1; i < 2 ** pdt_pkg::CFG_IDX_W; i++)
            write_reg(i[pdt_pkg::CFG_IDX_W-1:0], {$urandom, $urandom});
        repeat (5)
            add_move(mk_move(pdt_pkg::CMD_MOVE_IN, 0, 0, SIZE_MAX, SIZE_MAX,
                             1'b0, 1'b0));
        add_move(mk_move(pdt_pkg::CMD_MOVE_IN, COORD_MIN, COORD_MAX, SIZE_MAX,
                         SIZE_MAX, 1'b0, 1'b0));
        add_move(mk_move(pdt_pkg::CMD_MOVE_OUT, COORD_MAX, COORD_MIN, SIZE_MAX,
                         SIZE_MAX, 1'b1, 1'b0));
        wait_drained();

        // largest total area
        write_reg(pdt_pkg::REG_TOTAL_AREA, AREA_MAX);
        add_move(mk_move(pdt_pkg::CMD_MOVE_IN, 0, 0, 1000, 1000, 1'b0, 1'b0));
        add_move(mk_move(pdt_pkg::CMD_MOVE_IN, 0, 0, SIZE_MAX, SIZE_MAX, 1'b1, 1'b0));
        wait_drained();

        // inverted limits: every move misses
        write_bin(10, -10, 0, 100, 2000);
        add_move(mk_move(pdt_pkg::CMD_MOVE_IN, 0, 50, 100, 100, 1'b0, 1'b0));
        add_move(mk_move(pdt_pkg::CMD_MOVE_OUT, 0, 50, 100, 100, 1'b0, 1'b0));
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            random_bin();
            quiet_in  = ($urandom_range(0, 3) == 0);
            quiet_out = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < MOVES_PER_PHASE; k++)
                add_move(rand_move());
            wait_drained();
        end

        // catch anything the block sends after the last expected result
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
